@@ rtl/envc_pkg.sv @@
package envc_pkg;

  // Reading kinds carried on the input tuser and echoed on the output tuser.
  typedef enum logic [1:0] {
    OP_TEMP  = 2'd0,
    OP_PRESS = 2'd1,
    OP_HUM   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TRIM_TEMP    = 3'd0,
    REG_TRIM_PRESS_A = 3'd1,
    REG_TRIM_PRESS_B = 3'd2,
    REG_TRIM_PRESS_C = 3'd3,
    REG_TRIM_HUM     = 3'd4
  } reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_MUL,
    ST_DIV
  } state_e;

  // Kind of one program step.
  typedef enum logic [1:0] {
    UOP_ALU,
    UOP_MUL,
    UOP_DIV,
    UOP_FIN
  } uop_e;

  // Working register that receives a multiply or divide result.
  typedef enum logic [2:0] {
    DST_A,
    DST_B,
    DST_C,
    DST_D,
    DST_E
  } dst_e;

  localparam int unsigned DataW  = 64;
  localparam int unsigned ValueW = 33;

  typedef struct packed {
    logic                    start;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DataW-1:0] res;
  } arith_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [ValueW-1:0] value;
    logic              div_zero;
  } result_t;

  // Sign-extend the low 32 bits of a word.
  function automatic logic signed [DataW-1:0] s32(input logic [DataW-1:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

endpackage

@@ rtl/envc_mul.sv @@
module envc_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  envc_pkg::arith_req_t req_i,
  output envc_pkg::arith_rsp_t rsp_o
);

  logic [63:0] a_q, a_d;
  logic [63:0] b_q, b_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  // One 4-bit digit of the multiplier per cycle, low 64 product bits kept.
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = req_i.a;
      b_d    = req_i.b;
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + (a_q * 64'(b_q[3:0]));
      a_d   = a_q << 4;
      b_d   = b_q >> 4;
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;

endmodule

@@ rtl/envc_div.sv @@
module envc_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  envc_pkg::arith_req_t req_i,
  output envc_pkg::arith_rsp_t rsp_o
);

  logic [63:0] quo_q, quo_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;

  // Signed division truncating toward zero: magnitudes are divided one
  // quotient bit per cycle by restoring subtraction, then the sign applied.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[63]};
    if (req_i.start) begin
      neg_d  = req_i.a[63] ^ req_i.b[63];
      quo_d  = req_i.a[63] ? 64'(-req_i.a) : req_i.a;
      den_d  = req_i.b[63] ? 64'(-req_i.b) : req_i.b;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = 64'(trial - {1'b0, den_q});
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = neg_q ? 64'(-quo_q) : quo_q;

endmodule

@@ rtl/envc_seq.sv @@
module envc_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           op_i,
  input  logic [19:0]          raw_i,
  output logic                 idle_o,
  input  logic                 out_free_i,
  output envc_pkg::result_t    res_o,
  input  logic [47:0]          trim_temp_i,
  input  logic [63:0]          trim_press_a_i,
  input  logic [63:0]          trim_press_b_i,
  input  logic [15:0]          trim_press_c_i,
  input  logic [63:0]          trim_hum_i,
  output envc_pkg::arith_req_t mul_req_o,
  input  envc_pkg::arith_rsp_t mul_rsp_i,
  output envc_pkg::arith_req_t div_req_o,
  input  envc_pkg::arith_rsp_t div_rsp_i
);

  envc_pkg::state_e state_q, state_d;
  logic [4:0]       step_q, step_d;
  logic [1:0]       op_q;
  logic [19:0]      raw_q;
  logic [31:0]      ft_q, ft_d;
  logic signed [63:0] a_q, b_q, c_q, d_q, e_q;
  logic signed [63:0] a_n, b_n, c_n, d_n, e_n;

  // Program step decode.
  envc_pkg::uop_e   uop;
  envc_pkg::dst_e   dst;
  logic             w32;
  logic signed [63:0] opa, opb;
  logic [32:0]      fin_val;
  logic             fin_dz;
  logic             ft_we;
  logic [31:0]      ft_n;
  logic signed [63:0] wb;

  // Trim words, sign- or zero-extended to 64 bits.
  logic signed [63:0] t1, t2, t3;
  logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [63:0] h1, h2, h3, h4, h5, h6;
  logic signed [63:0] adc, adc_h, ft_s, hv;

  assign t1 = {48'd0, trim_temp_i[15:0]};
  assign t2 = {{48{trim_temp_i[31]}}, trim_temp_i[31:16]};
  assign t3 = {{48{trim_temp_i[47]}}, trim_temp_i[47:32]};
  assign p1 = {48'd0, trim_press_a_i[15:0]};
  assign p2 = {{48{trim_press_a_i[31]}}, trim_press_a_i[31:16]};
  assign p3 = {{48{trim_press_a_i[47]}}, trim_press_a_i[47:32]};
  assign p4 = {{48{trim_press_a_i[63]}}, trim_press_a_i[63:48]};
  assign p5 = {{48{trim_press_b_i[15]}}, trim_press_b_i[15:0]};
  assign p6 = {{48{trim_press_b_i[31]}}, trim_press_b_i[31:16]};
  assign p7 = {{48{trim_press_b_i[47]}}, trim_press_b_i[47:32]};
  assign p8 = {{48{trim_press_b_i[63]}}, trim_press_b_i[63:48]};
  assign p9 = {{48{trim_press_c_i[15]}}, trim_press_c_i};
  assign h1 = {56'd0, trim_hum_i[7:0]};
  assign h2 = {{48{trim_hum_i[23]}}, trim_hum_i[23:8]};
  assign h3 = {56'd0, trim_hum_i[31:24]};
  assign h4 = {{52{trim_hum_i[43]}}, trim_hum_i[43:32]};
  assign h5 = {{52{trim_hum_i[55]}}, trim_hum_i[55:44]};
  assign h6 = {{56{trim_hum_i[63]}}, trim_hum_i[63:56]};

  assign adc   = {44'd0, raw_q};
  assign adc_h = {48'd0, raw_q[15:0]};
  assign ft_s  = envc_pkg::s32({32'd0, ft_q});
  assign hv    = envc_pkg::s32(a_q);

  // The program: one case arm per step, multiplies and the divide handed off.
  always_comb begin
    uop     = envc_pkg::UOP_ALU;
    dst     = envc_pkg::DST_A;
    w32     = 1'b0;
    opa     = '0;
    opb     = '0;
    fin_val = '0;
    fin_dz  = 1'b0;
    ft_we   = 1'b0;
    ft_n    = ft_q;
    a_n = a_q; b_n = b_q; c_n = c_q; d_n = d_q; e_n = e_q;
    case (envc_pkg::op_e'(op_q))
      envc_pkg::OP_TEMP: begin
        case (step_q)
          5'd0: a_n = (adc >>> 3) - (t1 <<< 1);
          5'd1: begin uop = envc_pkg::UOP_MUL; opa = a_q; opb = t2; dst = envc_pkg::DST_A; end
          5'd2: begin a_n = a_q >>> 11; b_n = (adc >>> 4) - t1; end
          5'd3: begin uop = envc_pkg::UOP_MUL; opa = b_q; opb = b_q; dst = envc_pkg::DST_B; end
          5'd4: b_n = b_q >>> 12;
          5'd5: begin uop = envc_pkg::UOP_MUL; opa = b_q; opb = t3; dst = envc_pkg::DST_B; end
          5'd6: begin
            ft_we = 1'b1;
            ft_n  = 32'(a_q + (b_q >>> 14));
          end
          5'd7: c_n = (ft_s <<< 2) + ft_s + 64'sd128;
          default: begin
            uop     = envc_pkg::UOP_FIN;
            fin_val = 33'(c_q >>> 8);
          end
        endcase
      end
      envc_pkg::OP_PRESS: begin
        case (step_q)
          5'd0:  a_n = ft_s - 64'sd128000;
          5'd1:  begin uop = envc_pkg::UOP_MUL; opa = a_q; opb = a_q; dst = envc_pkg::DST_B; end
          5'd2:  begin uop = envc_pkg::UOP_MUL; opa = b_q; opb = p6; dst = envc_pkg::DST_C; end
          5'd3:  begin uop = envc_pkg::UOP_MUL; opa = a_q; opb = p5; dst = envc_pkg::DST_D; end
          5'd4:  c_n = c_q + (d_q <<< 17);
          5'd5:  c_n = c_q + (p4 <<< 35);
          5'd6:  begin uop = envc_pkg::UOP_MUL; opa = b_q; opb = p3; dst = envc_pkg::DST_D; end
          5'd7:  d_n = d_q >>> 8;
          5'd8:  begin uop = envc_pkg::UOP_MUL; opa = a_q; opb = p2; dst = envc_pkg::DST_E; end
          5'd9:  a_n = d_q + (e_q <<< 12);
          5'd10: a_n = (64'sd1 <<< 47) + a_q;
          5'd11: begin uop = envc_pkg::UOP_MUL; opa = a_q; opb = p1; dst = envc_pkg::DST_A; end
          5'd12: a_n = a_q >>> 33;
          5'd13: begin
            // A zero divisor ends the item with the flag set.
            if (a_q == 64'sd0) begin
              uop    = envc_pkg::UOP_FIN;
              fin_dz = 1'b1;
            end else begin
              b_n = ((64'sd1048576 - adc) <<< 31) - c_q;
            end
          end
          5'd14: begin uop = envc_pkg::UOP_MUL; opa = b_q; opb = 64'sd3125; dst = envc_pkg::DST_B; end
          5'd15: begin uop = envc_pkg::UOP_DIV; opa = b_q; opb = a_q; dst = envc_pkg::DST_B; end
          5'd16: c_n = b_q >>> 13;
          5'd17: begin uop = envc_pkg::UOP_MUL; opa = p9; opb = c_q; dst = envc_pkg::DST_D; end
          5'd18: begin uop = envc_pkg::UOP_MUL; opa = d_q; opb = c_q; dst = envc_pkg::DST_D; end
          5'd19: d_n = d_q >>> 25;
          5'd20: begin uop = envc_pkg::UOP_MUL; opa = p8; opb = b_q; dst = envc_pkg::DST_E; end
          5'd21: e_n = b_q + d_q + (e_q >>> 19);
          default: begin
            uop     = envc_pkg::UOP_FIN;
            fin_val = 33'((e_q >>> 8) + (p7 <<< 4));
          end
        endcase
      end
      envc_pkg::OP_HUM: begin
        // Humidity works in 32-bit wrap; words stay sign-extended from bit 31.
        w32 = 1'b1;
        case (step_q)
          5'd0:  a_n = envc_pkg::s32(ft_s - 64'sd76800);
          5'd1:  begin uop = envc_pkg::UOP_MUL; opa = h5; opb = a_q; dst = envc_pkg::DST_B; end
          5'd2:  b_n = envc_pkg::s32((adc_h <<< 14) - (h4 <<< 20) - b_q);
          5'd3:  b_n = envc_pkg::s32(b_q + 64'sd16384) >>> 15;
          5'd4:  begin uop = envc_pkg::UOP_MUL; opa = a_q; opb = h6; dst = envc_pkg::DST_C; end
          5'd5:  c_n = c_q >>> 10;
          5'd6:  begin uop = envc_pkg::UOP_MUL; opa = a_q; opb = h3; dst = envc_pkg::DST_D; end
          5'd7:  d_n = envc_pkg::s32((d_q >>> 11) + 64'sd32768);
          5'd8:  begin uop = envc_pkg::UOP_MUL; opa = c_q; opb = d_q; dst = envc_pkg::DST_C; end
          5'd9:  c_n = envc_pkg::s32((c_q >>> 10) + 64'sd2097152);
          5'd10: begin uop = envc_pkg::UOP_MUL; opa = c_q; opb = h2; dst = envc_pkg::DST_C; end
          5'd11: c_n = envc_pkg::s32(c_q + 64'sd8192) >>> 14;
          5'd12: begin uop = envc_pkg::UOP_MUL; opa = b_q; opb = c_q; dst = envc_pkg::DST_A; end
          5'd13: d_n = a_q >>> 15;
          5'd14: begin uop = envc_pkg::UOP_MUL; opa = d_q; opb = d_q; dst = envc_pkg::DST_D; end
          5'd15: d_n = d_q >>> 7;
          5'd16: begin uop = envc_pkg::UOP_MUL; opa = d_q; opb = h1; dst = envc_pkg::DST_D; end
          5'd17: a_n = envc_pkg::s32(a_q - (d_q >>> 4));
          default: begin
            // Clamp to the valid range, then drop to Q22.10.
            uop = envc_pkg::UOP_FIN;
            if (hv < 64'sd0) begin
              fin_val = '0;
            end else if (hv > 64'sd419430400) begin
              fin_val = 33'(64'sd419430400 >>> 12);
            end else begin
              fin_val = 33'(hv >>> 12);
            end
          end
        endcase
      end
      default: uop = envc_pkg::UOP_FIN;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      envc_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = envc_pkg::ST_RUN;
          step_d  = '0;
        end
      end
      envc_pkg::ST_RUN: begin
        case (uop)
          envc_pkg::UOP_MUL: state_d = envc_pkg::ST_MUL;
          envc_pkg::UOP_DIV: state_d = envc_pkg::ST_DIV;
          envc_pkg::UOP_FIN: if (out_free_i) state_d = envc_pkg::ST_IDLE;
          default: step_d = step_q + 5'd1;
        endcase
      end
      envc_pkg::ST_MUL: begin
        if (mul_rsp_i.done) begin
          state_d = envc_pkg::ST_RUN;
          step_d  = step_q + 5'd1;
        end
      end
      envc_pkg::ST_DIV: begin
        if (div_rsp_i.done) begin
          state_d = envc_pkg::ST_RUN;
          step_d  = step_q + 5'd1;
        end
      end
      default: state_d = envc_pkg::ST_IDLE;
    endcase
  end

  // Outputs toward the arithmetic units and the result register.
  always_comb begin
    mul_req_o.start = (state_q == envc_pkg::ST_RUN) && (uop == envc_pkg::UOP_MUL);
    mul_req_o.a     = opa;
    mul_req_o.b     = opb;
    div_req_o.start = (state_q == envc_pkg::ST_RUN) && (uop == envc_pkg::UOP_DIV);
    div_req_o.a     = opa;
    div_req_o.b     = opb;
    res_o.valid     = (state_q == envc_pkg::ST_RUN) && (uop == envc_pkg::UOP_FIN) &&
                      out_free_i;
    res_o.kind      = op_q;
    res_o.value     = fin_val;
    res_o.div_zero  = fin_dz;
    idle_o          = (state_q == envc_pkg::ST_IDLE);
  end

  // Writeback value from whichever unit finished.
  always_comb begin
    wb = (state_q == envc_pkg::ST_DIV) ? div_rsp_i.res : mul_rsp_i.res;
    if (w32) begin
      wb = envc_pkg::s32(wb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= envc_pkg::ST_IDLE;
      step_q  <= '0;
      ft_q    <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ft_q    <= ft_d;
    end
  end

  assign ft_d = ((state_q == envc_pkg::ST_RUN) && ft_we) ? ft_n : ft_q;

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (start_i && idle_o) begin
      op_q  <= op_i;
      raw_q <= raw_i;
    end
    if (state_q == envc_pkg::ST_RUN && uop == envc_pkg::UOP_ALU) begin
      a_q <= a_n; b_q <= b_n; c_q <= c_n; d_q <= d_n; e_q <= e_n;
    end else if ((state_q == envc_pkg::ST_MUL && mul_rsp_i.done) ||
                 (state_q == envc_pkg::ST_DIV && div_rsp_i.done)) begin
      case (dst)
        envc_pkg::DST_A: a_q <= wb;
        envc_pkg::DST_B: b_q <= wb;
        envc_pkg::DST_C: c_q <= wb;
        envc_pkg::DST_D: d_q <= wb;
        default:         e_q <= wb;
      endcase
    end
  end

  // A multiply is only launched from a running step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req_o.start |-> state_q == envc_pkg::ST_RUN)
    else $error("multiply started outside a running step");

  // Unit completions arrive only while the sequencer waits for them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp_i.done |-> state_q == envc_pkg::ST_MUL)
    else $error("multiply finished while not waited for");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> state_q == envc_pkg::ST_DIV)
    else $error("divide finished while not waited for");

  // A finished item returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> state_q == envc_pkg::ST_IDLE)
    else $error("sequencer did not retire the item");

endmodule

@@ rtl/env_sensor_compensation.sv @@
// Channel   Dir  tdata                      tuser
// s_axis    in   raw_reading [19:0]         op [1:0]
// m_axis    out  value [32:0]               kind [1:0], div_zero [2]
// cfg       in   cfg_data_i (trim words)    cfg_addr_i selects the register
//
// One item is worked on at a time by a step sequencer sharing a 4-bit digit
// multiplier and a 1-bit restoring divider. Reset clears the trim registers,
// the fine-temperature term and all control state. The result register frees
// the sequencer: s_axis_tready rises again while a result waits on m_axis,
// and a stalled m_axis holds only the next result in its last step.
module env_sensor_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // raw_reading [19:0], zero fill
  input  logic [1:0]  s_axis_tuser,   // op [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // value [32:0], zero fill
  output logic [2:0]  m_axis_tuser,   // kind [1:0], div_zero [2]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [63:0] cfg_data_i
);

  logic [47:0] trim_temp_q;
  logic [63:0] trim_press_a_q;
  logic [63:0] trim_press_b_q;
  logic [15:0] trim_press_c_q;
  logic [63:0] trim_hum_q;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_kind_q;
  logic [32:0] out_value_q;
  logic        out_dz_q;
  logic        out_free;
  logic        seq_idle;

  envc_pkg::result_t    res;
  envc_pkg::arith_req_t mul_req, div_req;
  envc_pkg::arith_rsp_t mul_rsp, div_rsp;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_temp_q    <= '0;
      trim_press_a_q <= '0;
      trim_press_b_q <= '0;
      trim_press_c_q <= '0;
      trim_hum_q     <= '0;
    end else if (cfg_we_i) begin
      case (envc_pkg::reg_e'(cfg_addr_i))
        envc_pkg::REG_TRIM_TEMP:    trim_temp_q    <= cfg_data_i[47:0];
        envc_pkg::REG_TRIM_PRESS_A: trim_press_a_q <= cfg_data_i;
        envc_pkg::REG_TRIM_PRESS_B: trim_press_b_q <= cfg_data_i;
        envc_pkg::REG_TRIM_PRESS_C: trim_press_c_q <= cfg_data_i[15:0];
        envc_pkg::REG_TRIM_HUM:     trim_hum_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = seq_idle;
  assign out_free      = !out_valid_q || m_axis_tready;

  envc_seq u_seq (
    .clk_i,
    .rst_ni,
    .start_i        (s_axis_tvalid && s_axis_tready),
    .op_i           (s_axis_tuser),
    .raw_i          (s_axis_tdata[19:0]),
    .idle_o         (seq_idle),
    .out_free_i     (out_free),
    .res_o          (res),
    .trim_temp_i    (trim_temp_q),
    .trim_press_a_i (trim_press_a_q),
    .trim_press_b_i (trim_press_b_q),
    .trim_press_c_i (trim_press_c_q),
    .trim_hum_i     (trim_hum_q),
    .mul_req_o      (mul_req),
    .mul_rsp_i      (mul_rsp),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp)
  );

  envc_mul u_mul (
    .clk_i,
    .rst_ni,
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  envc_div u_div (
    .clk_i,
    .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_kind_q  <= res.kind;
      out_value_q <= res.value;
      out_dz_q    <= res.div_zero;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_value_q};
  assign m_axis_tuser  = {out_dz_q, out_kind_q};

endmodule
